FILE: hw/rtl/cslot_pkg.sv
// shared types and constants of the chunked slot group allocator
`timescale 1ns / 1ps

package cslot_pkg;

    localparam int OPW = 2;
    localparam int GSW = 7;
    localparam int POSW = 11;
    localparam int STW = 2;
    localparam int FSW = 10;
    localparam int TOPW = 11;
    localparam int CLW = 4;

    localparam logic [OPW-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPW-1:0] OP_FREE  = 2'd1;
    localparam logic [OPW-1:0] OP_RESET = 2'd2;

    localparam logic [STW-1:0] ST_OK      = 2'd0;
    localparam logic [STW-1:0] ST_FULL    = 2'd1;
    localparam logic [STW-1:0] ST_TOO_BIG = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    localparam logic [CLW-1:0] CL2_RESET = 4'd6;

    // busy map row geometry
    localparam int ROW_W = 32;
    localparam int ROW_BITS = 5;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0]      kind;
        logic [STW-1:0]  status;
        logic [GSW-1:0]  group;
        logic [POSW-1:0] pos;
        logic [CLW-1:0]  cl2;
    } cslot_cmd_t;

    typedef struct packed {
        logic init_done;
    } back_stat_t;

endpackage

FILE: hw/rtl/cslot_if.sv
// handshake interfaces for request, response and configuration beats
`timescale 1ns / 1ps

interface cslot_req_if
    import cslot_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [OPW-1:0]  operation;
    logic [GSW-1:0]  group_size;
    logic [POSW-1:0] position;

    modport source (output valid, output operation, output group_size, output position,
                    input ready);
    modport sink (input valid, input operation, input group_size, input position,
                  output ready);
endinterface

interface cslot_rsp_if
    import cslot_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [STW-1:0]  status;
    logic [FSW-1:0]  first_slot;
    logic            conflict;
    logic [TOPW-1:0] top;

    modport source (output valid, output status, output first_slot, output conflict,
                    output top, input ready);
    modport sink (input valid, input status, input first_slot, input conflict,
                  input top, output ready);
endinterface

interface cslot_cfg_if
    import cslot_pkg::*;
;
    logic           valid;
    logic           ready;
    logic [CLW-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/chunked_slot_group_allocator.sv
// steps per request: a free of an inner slot reads and writes its row of the busy map;
// an allocate aligns, checks, then reads and writes each touched row of 32 slots;
// a free of the top slot then scans rows downward for the new top; reset top clears each
// row from the new top to the end of the map; the row sequencer handles one item at a time
// after reset a clearing pass over every row of the busy map runs before requests
// are taken; the configuration port stays open throughout
`timescale 1ns / 1ps

module chunked_slot_group_allocator
    import cslot_pkg::*;
#(
    parameter int SLOTS = 1024,
    parameter int MAX_GROUP = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    cslot_cfg_if.sink    cfg,
    cslot_req_if.sink    req,
    cslot_rsp_if.source  rsp
);

    back_stat_t stat;
    logic       push;
    cslot_cmd_t push_cmd;
    logic       push_ready;
    logic       pop;
    cslot_cmd_t pop_cmd;
    logic       pop_valid;

    cslot_front #(
        .SLOTS     (SLOTS),
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .stat       (stat),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    cslot_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid)
    );

    cslot_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (pop_cmd),
        .q_valid (pop_valid),
        .q_pop   (pop),
        .stat    (stat),
        .rsp     (rsp)
    );

endmodule

FILE: hw/rtl/cslot_front.sv
// front end: chunk size register and request classification
`timescale 1ns / 1ps

module cslot_front
    import cslot_pkg::*;
#(
    parameter int SLOTS = 1024,
    parameter int MAX_GROUP = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    cslot_cfg_if.sink        cfg,
    cslot_req_if.sink        req,
    input  back_stat_t       stat,
    output logic             push,
    output cslot_cmd_t       push_cmd,
    input  logic             push_ready
);

    localparam int SAT = (SLOTS > 2047) ? 2047 : SLOTS;

    logic [CLW-1:0] cl2_reg;
    logic [16:0]    csize;
    logic           too_big;
    logic           free_ok;
    logic [POSW-1:0] pos_sat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl2_reg <= CL2_RESET;
        end
        else if (cfg.valid)
        begin
            cl2_reg <= cfg.data;
        end
    end

    assign req.ready = push_ready && stat.init_done;
    assign push = req.valid && req.ready;

    always_comb
    begin
        csize = 17'd1 << cl2_reg;
        too_big = ({10'd0, req.group_size} > csize)
               || ({25'd0, req.group_size} > 32'(MAX_GROUP));
        free_ok = {21'd0, req.position} < 32'(SLOTS);
        pos_sat = ({21'd0, req.position} > 32'(SAT)) ? POSW'(SAT) : req.position;

        push_cmd.kind = KIND_NONE;
        push_cmd.status = ST_OK;
        push_cmd.group = req.group_size;
        push_cmd.pos = req.position;
        push_cmd.cl2 = cl2_reg;
        case (req.operation)
            OP_ALLOC:
            begin
                if (too_big)
                begin
                    push_cmd.status = ST_TOO_BIG;
                end
                else if (req.group_size != '0)
                begin
                    push_cmd.kind = KIND_ALLOC;
                end
            end
            OP_FREE:
            begin
                if (free_ok)
                begin
                    push_cmd.kind = KIND_FREE;
                end
            end
            OP_RESET:
            begin
                push_cmd.kind = KIND_RESET;
                push_cmd.pos = pos_sat;
            end
            default:
            begin
                push_cmd.kind = KIND_NONE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cslot_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps

module cslot_queue
    import cslot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cslot_cmd_t push_cmd,
    output logic       push_ready,
    input  logic       pop,
    output cslot_cmd_t pop_cmd,
    output logic       pop_valid
);

    localparam int QPW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    cslot_cmd_t       entry_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;

    assign push_ready = count_reg != QCW'(QDEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && pop_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && pop_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= QPW'(wr_ptr_reg + 1'b1);
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= QPW'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/cslot_back.sv
// back end: busy map memory, row sequencer, top tracking and result register
`timescale 1ns / 1ps

module cslot_back
    import cslot_pkg::*;
#(
    parameter int SLOTS = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cslot_cmd_t q_cmd,
    input  logic       q_valid,
    output logic       q_pop,
    output back_stat_t stat,
    cslot_rsp_if.source rsp
);

    localparam int ROWS = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW = $clog2(SLOTS + 1);
    localparam int SW = $clog2(SLOTS + 254);
    localparam int AW = ((SW > 16) ? SW : 16) + 1;
    localparam logic [SW-1:0] SLOTS_S = SW'(SLOTS);
    localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ALIGN = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_WR    = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SCHK  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rdata_reg;
    logic             mem_we;
    logic [RAW-1:0]   mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [RAW-1:0]   mem_raddr;

    logic [3:0]     st_reg, st_next;
    logic [TW-1:0]  top_reg, top_next;
    logic [RAW-1:0] row_reg, row_next;
    logic           out_valid_reg, out_valid_next;
    logic           need_scan_reg, need_scan_next;

    logic [SW-1:0]  lo_reg, lo_next;
    logic [SW-1:0]  hi_reg, hi_next;
    logic [RAW-1:0] last_row_reg, last_row_next;
    logic [SW-1:0]  scan_reg, scan_next;
    logic [SW-1:0]  grp_reg, grp_next;
    logic [CLW-1:0] cl2_reg, cl2_next;
    logic [1:0]     mode_reg, mode_next;
    logic           conflict_reg, conflict_next;
    logic [STW-1:0] status_reg, status_next;
    logic [SW-1:0]  first_reg, first_next;

    logic [STW-1:0]  out_status_reg, out_status_next;
    logic [FSW-1:0]  out_first_reg, out_first_next;
    logic            out_conflict_reg, out_conflict_next;
    logic [TOPW-1:0] out_top_reg, out_top_next;

    logic [ROW_W-1:0] row_mask;
    logic [ROW_W-1:0] scan_hits;
    logic [ROW_BITS-1:0] hit_idx;
    logic [SW-1:0]    row_base;
    logic [SW-1:0]    scan_base;
    logic [RAW-1:0]   scan_row;
    logic [SW-1:0]    q_pos;

    logic [AW-1:0] t_a, g_a, sum_a, aligned_a, c_a, off_a;
    logic          moved;
    logic [SW-1:0] end_s;

    assign stat.init_done = st_reg != S_INIT;
    assign scan_row = RAW'(scan_reg >> ROW_BITS);
    assign scan_base = SW'(scan_row) << ROW_BITS;
    assign row_base = SW'(row_reg) << ROW_BITS;
    assign q_pos = SW'(q_cmd.pos);
    assign mem_raddr = (st_reg == S_SRD) ? scan_row : row_reg;

    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.first_slot = out_first_reg;
    assign rsp.conflict = out_conflict_reg;
    assign rsp.top = out_top_reg;

    // slots of the current row inside [lo, hi)
    always_comb
    begin
        logic [SW-1:0] slot;
        for (int j = 0; j < ROW_W; j++)
        begin
            slot = row_base + SW'(j);
            row_mask[j] = (slot >= lo_reg) && (slot < hi_reg);
        end
    end

    // highest busy slot at or below the scan point
    always_comb
    begin
        hit_idx = '0;
        for (int j = 0; j < ROW_W; j++)
        begin
            scan_hits[j] = rdata_reg[j] && (ROW_BITS'(j) <= scan_reg[ROW_BITS-1:0]);
            if (scan_hits[j])
            begin
                hit_idx = ROW_BITS'(j);
            end
        end
    end

    // chunk alignment of the allocation start
    always_comb
    begin
        t_a = AW'(top_reg);
        g_a = AW'(grp_reg);
        sum_a = t_a + g_a - AW'(1);
        aligned_a = (sum_a >> cl2_reg) << cl2_reg;
        c_a = AW'(1) << cl2_reg;
        off_a = t_a & (c_a - AW'(1));
        moved = (off_a == '0) || ((off_a + g_a) > c_a);
        end_s = lo_reg + grp_reg;
    end

    always_comb
    begin
        st_next = st_reg;
        top_next = top_reg;
        row_next = row_reg;
        need_scan_next = need_scan_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        last_row_next = last_row_reg;
        scan_next = scan_reg;
        grp_next = grp_reg;
        cl2_next = cl2_reg;
        mode_next = mode_reg;
        conflict_next = conflict_reg;
        status_next = status_reg;
        first_next = first_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_first_next = out_first_reg;
        out_conflict_next = out_conflict_reg;
        out_top_next = out_top_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        mem_waddr = row_reg;
        mem_wdata = '0;

        case (st_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (row_reg == LAST_ROW)
                begin
                    row_next = '0;
                    st_next = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    mode_next = q_cmd.kind;
                    status_next = ST_OK;
                    first_next = '0;
                    conflict_next = 1'b0;
                    need_scan_next = 1'b0;
                    case (q_cmd.kind)
                        KIND_ALLOC:
                        begin
                            grp_next = SW'(q_cmd.group);
                            cl2_next = q_cmd.cl2;
                            st_next = S_ALIGN;
                        end
                        KIND_FREE:
                        begin
                            lo_next = q_pos;
                            hi_next = q_pos + 1'b1;
                            scan_next = q_pos;
                            row_next = RAW'(q_pos >> ROW_BITS);
                            last_row_next = RAW'(q_pos >> ROW_BITS);
                            need_scan_next = (top_reg != '0)
                                          && (SW'(top_reg) - 1'b1 == q_pos);
                            st_next = S_RD;
                        end
                        KIND_RESET:
                        begin
                            lo_next = q_pos;
                            hi_next = SLOTS_S;
                            row_next = RAW'(q_pos >> ROW_BITS);
                            last_row_next = LAST_ROW;
                            top_next = TW'(q_cmd.pos);
                            st_next = (q_pos >= SLOTS_S) ? S_DONE : S_RD;
                        end
                        default:
                        begin
                            status_next = q_cmd.status;
                            st_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ALIGN:
            begin
                lo_next = SW'(moved ? aligned_a : t_a);
                st_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (end_s > SLOTS_S)
                begin
                    status_next = ST_FULL;
                    st_next = S_DONE;
                end
                else
                begin
                    hi_next = end_s;
                    first_next = lo_reg;
                    row_next = RAW'(lo_reg >> ROW_BITS);
                    last_row_next = RAW'((end_s - 1'b1) >> ROW_BITS);
                    st_next = S_RD;
                end
            end
            S_RD:
            begin
                st_next = S_WR;
            end
            S_WR:
            begin
                mem_we = 1'b1;
                if (mode_reg == KIND_ALLOC)
                begin
                    mem_wdata = rdata_reg | row_mask;
                    conflict_next = conflict_reg || ((rdata_reg & row_mask) != '0);
                end
                else
                begin
                    mem_wdata = rdata_reg & ~row_mask;
                end
                if (row_reg == last_row_reg)
                begin
                    if (mode_reg == KIND_ALLOC)
                    begin
                        top_next = TW'(hi_reg);
                        st_next = S_DONE;
                    end
                    else if (mode_reg == KIND_FREE && need_scan_reg)
                    begin
                        st_next = S_SRD;
                    end
                    else
                    begin
                        st_next = S_DONE;
                    end
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    st_next = S_RD;
                end
            end
            S_SRD:
            begin
                st_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (scan_hits != '0)
                begin
                    top_next = TW'(scan_base + SW'(hit_idx) + 1'b1);
                    st_next = S_DONE;
                end
                else if (scan_row == '0)
                begin
                    top_next = '0;
                    st_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_base - 1'b1;
                    st_next = S_SRD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = status_reg;
                    out_first_next = FSW'(first_reg);
                    out_conflict_next = conflict_reg;
                    out_top_next = TOPW'(top_reg);
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_INIT;
            top_reg <= '0;
            row_reg <= '0;
            out_valid_reg <= 1'b0;
            need_scan_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            top_reg <= top_next;
            row_reg <= row_next;
            out_valid_reg <= out_valid_next;
            need_scan_reg <= need_scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        last_row_reg <= last_row_next;
        scan_reg <= scan_next;
        grp_reg <= grp_next;
        cl2_reg <= cl2_next;
        mode_reg <= mode_next;
        conflict_reg <= conflict_next;
        status_reg <= status_next;
        first_reg <= first_next;
        out_status_reg <= out_status_next;
        out_first_reg <= out_first_next;
        out_conflict_reg <= out_conflict_next;
        out_top_reg <= out_top_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[mem_raddr];
    end

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(SLOTS))
        else $error("stack top beyond slot count");

    a_row_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_WR && row_reg != last_row_reg)
        |=> (st_reg == S_RD && row_reg == RAW'($past(row_reg) + 1'b1)))
        else $error("row sequencer skipped a row");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DONE && (!out_valid_reg || rsp.ready))
        |=> (out_valid_reg && st_reg == S_IDLE))
        else $error("finished request not presented");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (st_reg == S_INIT || st_reg == S_WR))
        else $error("busy map written outside a write step");

endmodule
